// ----- rtl/core/mitd_pkg.sv -----
// Shared types, constants and helpers for the multi-input time debouncer.
package mitd_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int NOW_W = 32;
  localparam int CFG_W = 16;
  localparam int POL_W = 5;
  localparam int NUM_CH = 4;

  localparam int CH_PLED = 0;
  localparam int CH_STRIP = 1;
  localparam int CH_PBTN = 2;
  localparam int CH_RBTN = 3;

  localparam int POL_PLED = 0;
  localparam int POL_ACT = 1;
  localparam int POL_STRIP = 2;
  localparam int POL_PBTN = 3;
  localparam int POL_RBTN = 4;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [CFG_W-1:0] POLL_RESET = 16'd5;
  localparam logic [POL_W-1:0] POLARITY_RESET = 5'h1f;

  typedef enum logic [1:0] {
    CFG_DEBOUNCE_TIME = 2'd0,
    CFG_POLL_INTERVAL = 2'd1,
    CFG_POLARITY_MASK = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_LOW  = 2'd0,
    ST_HIGH = 2'd1,
    ST_RISE = 2'd2,
    ST_FALL = 2'd3
  } pin_state_e;

  typedef struct packed {
    logic start;
    logic poll;
  } lane_ctrl_t;

  typedef struct packed {
    pin_state_e power_led;
    pin_state_e activity_led;
    pin_state_e power_button;
    pin_state_e reset_button;
    logic       strip_power;
  } result_t;

  function automatic pin_state_e level_state(input logic lvl);
    return lvl ? ST_HIGH : ST_LOW;
  endfunction

  function automatic pin_state_e edge_state(input logic lvl);
    return lvl ? ST_RISE : ST_FALL;
  endfunction

endpackage

// ----- rtl/core/multi_input_time_debouncer.sv -----
// Top level: config registers, poll timer, activity edge, four debounce lanes.
//
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------------------
//  in      | in_valid_i/in_stall_o  | opcode_i, now_ms_i, raw_*_i
//  out     | out_valid_o/out_stall_i| *_state_o, strip_power_present_o
//  cfg     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One beat per cycle while in_stall_o is low; each result is registered in the output buffer.
// All four lanes and the activity/poll logic update in the accept cycle.
// Reset loads default config and clears all channel state; no clearing pass.
// A two-entry result buffer absorbs output stalls; input stalls only when both fill.
module multi_input_time_debouncer import mitd_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             opcode_i,
  input  logic [NOW_W-1:0] now_ms_i,
  input  logic             raw_power_led_i,
  input  logic             raw_activity_led_i,
  input  logic             raw_strip_power_i,
  input  logic             raw_power_button_i,
  input  logic             raw_reset_button_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       power_led_state_o,
  output logic [1:0]       activity_led_state_o,
  output logic [1:0]       power_button_state_o,
  output logic [1:0]       reset_button_state_o,
  output logic             strip_power_present_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  logic [CFG_W-1:0]     debounce_q;
  logic [CFG_W-1:0]     poll_q;
  logic [POL_W-1:0]     pol_q;
  logic                 act_q;
  logic [TIME_BITS-1:0] last_poll_q, last_poll_d;
  logic [TIME_BITS-1:0] now_t;
  logic                 in_acc;
  logic                 poll_due;
  logic                 act_lvl;
  logic [NUM_CH-1:0]    lvl;
  logic [NUM_CH-1:0]    stable;
  pin_state_e           lane_state [NUM_CH];
  lane_ctrl_t           ctrl;
  pin_state_e           act_state;
  result_t              res;
  result_t              res_out;
  logic                 full;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RESET;
      poll_q     <= POLL_RESET;
      pol_q      <= POLARITY_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_DEBOUNCE_TIME: debounce_q <= cfg_data_i;
        CFG_POLL_INTERVAL: poll_q <= cfg_data_i;
        CFG_POLARITY_MASK: pol_q <= cfg_data_i[POL_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = full;
  assign in_acc     = in_valid_i && !full;
  assign now_t      = TIME_BITS'(now_ms_i);

  assign act_lvl         = raw_activity_led_i ^ ~pol_q[POL_ACT];
  assign lvl[CH_PLED]    = raw_power_led_i ^ ~pol_q[POL_PLED];
  assign lvl[CH_STRIP]   = raw_strip_power_i ^ ~pol_q[POL_STRIP];
  assign lvl[CH_PBTN]    = raw_power_button_i ^ ~pol_q[POL_PBTN];
  assign lvl[CH_RBTN]    = raw_reset_button_i ^ ~pol_q[POL_RBTN];

  assign poll_due   = (now_t - last_poll_q) >= TIME_BITS'(poll_q);
  assign ctrl.start = in_acc && !opcode_i;
  assign ctrl.poll  = in_acc && opcode_i && poll_due;

  always_comb begin
    last_poll_d = last_poll_q;
    if (ctrl.poll) begin
      last_poll_d = now_t;
    end
    if (opcode_i && (act_lvl != act_q)) begin
      act_state = edge_state(act_lvl);
    end else begin
      act_state = level_state(act_lvl);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= 1'b0;
      last_poll_q <= '0;
    end else begin
      last_poll_q <= last_poll_d;
      if (in_acc) begin
        act_q <= act_lvl;
      end
    end
  end

  for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
    mitd_lane #(
      .TimeBits(TIME_BITS)
    ) u_lane (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (ctrl),
      .level_i        (lvl[g]),
      .now_i          (now_t),
      .debounce_time_i(debounce_q),
      .state_o        (lane_state[g]),
      .stable_o       (stable[g])
    );
  end

  assign res.power_led    = lane_state[CH_PLED];
  assign res.activity_led = act_state;
  assign res.power_button = lane_state[CH_PBTN];
  assign res.reset_button = lane_state[CH_RBTN];
  assign res.strip_power  = stable[CH_STRIP];

  mitd_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_acc),
    .res_i      (res),
    .full_o     (full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (res_out)
  );

  assign power_led_state_o     = res_out.power_led;
  assign activity_led_state_o  = res_out.activity_led;
  assign power_button_state_o  = res_out.power_button;
  assign reset_button_state_o  = res_out.reset_button;
  assign strip_power_present_o = res_out.strip_power;

endmodule

// ----- rtl/core/mitd_lane.sv -----
// One debounced channel: stable level, candidate level and change time.
module mitd_lane import mitd_pkg::*; #(
  parameter int TimeBits = TIME_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lane_ctrl_t          ctrl_i,
  input  logic                level_i,
  input  logic [TimeBits-1:0] now_i,
  input  logic [CFG_W-1:0]    debounce_time_i,
  output pin_state_e          state_o,
  output logic                stable_o
);

  logic                stable_q, stable_d;
  logic                cand_q, cand_d;
  logic [TimeBits-1:0] chg_q, chg_d;
  logic [TimeBits-1:0] elapsed;

  always_comb begin
    stable_d = stable_q;
    cand_d   = cand_q;
    chg_d    = chg_q;
    elapsed  = '0;
    state_o  = level_state(stable_q);
    if (ctrl_i.start) begin
      stable_d = level_i;
      cand_d   = level_i;
      chg_d    = now_i;
      state_o  = level_state(level_i);
    end else if (ctrl_i.poll) begin
      cand_d = level_i;
      if (level_i != cand_q) begin
        chg_d   = now_i;
        elapsed = '0;
      end else begin
        elapsed = now_i - chg_q;
      end
      if ((stable_q != level_i) && (elapsed >= TimeBits'(debounce_time_i))) begin
        stable_d = level_i;
        state_o  = edge_state(level_i);
      end
    end
  end

  assign stable_o = stable_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b0;
      cand_q   <= 1'b0;
      chg_q    <= '0;
    end else begin
      stable_q <= stable_d;
      cand_q   <= cand_d;
      chg_q    <= chg_d;
    end
  end

endmodule

// ----- rtl/core/mitd_outbuf.sv -----
// Result register with skid entry that holds the merged lane results as one beat.
module mitd_outbuf import mitd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t res_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t res_o
);

  result_t main_q, main_d;
  result_t skid_q, skid_d;
  logic    main_vld_q, main_vld_d;
  logic    skid_vld_q, skid_vld_d;
  logic    take;

  assign take = main_vld_q && !out_stall_i;

  always_comb begin
    main_d     = main_q;
    skid_d     = skid_q;
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    if (take) begin
      if (skid_vld_q) begin
        main_d     = skid_q;
        skid_vld_d = 1'b0;
      end else begin
        main_vld_d = 1'b0;
      end
    end
    if (push_i) begin
      if (!main_vld_d) begin
        main_d     = res_i;
        main_vld_d = 1'b1;
      end else begin
        skid_d     = res_i;
        skid_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_vld_q;
  assign out_valid_o = main_vld_q;
  assign res_o       = main_q;

endmodule
